// File: src/xalt_pkg.sv
// Shared codes and types for the XML attribute line tokenizer.
package xalt_pkg;

  // Parser phases.
  localparam logic [2:0] PH_LEAD  = 3'd0;
  localparam logic [2:0] PH_TAG   = 3'd1;
  localparam logic [2:0] PH_GAP   = 3'd2;
  localparam logic [2:0] PH_KEY   = 3'd3;
  localparam logic [2:0] PH_EQ    = 3'd4;
  localparam logic [2:0] PH_VALUE = 3'd5;
  localparam logic [2:0] PH_SLASH = 3'd6;
  localparam logic [2:0] PH_DONE  = 3'd7;

  // Token classes.
  localparam logic [2:0] CL_BLANK = 3'd0;
  localparam logic [2:0] CL_TAG   = 3'd1;
  localparam logic [2:0] CL_KEY   = 3'd2;
  localparam logic [2:0] CL_VALUE = 3'd3;
  localparam logic [2:0] CL_MARK  = 3'd4;
  localparam logic [2:0] CL_AFTER = 3'd5;

  // Line status.
  localparam logic [1:0] ST_PARSING  = 2'd0;
  localparam logic [1:0] ST_ACCEPTED = 2'd1;
  localparam logic [1:0] ST_REJECTED = 2'd2;

  // Characters of the grammar.
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_GT    = 8'h3E;

  // Decision for one byte, handed from the classifier to the top level.
  typedef struct packed {
    logic [2:0] phase_next;
    logic [1:0] outcome_next;
    logic [2:0] token_class;
    logic       pair_end;
  } xalt_step_t;

endpackage

// File: src/xalt_classify.sv
// Per-byte classifier: next parser phase, outcome and token class for one byte.
module xalt_classify (
  input  logic [2:0]          phase,
  input  logic [1:0]          outcome,
  input  logic [7:0]          char_code,
  input  logic                line_start,
  output xalt_pkg::xalt_step_t step
);

  logic [2:0] cur_phase;
  logic [1:0] cur_outcome;
  logic       is_lower;
  logic       is_digit;
  logic       is_key;
  logic       reject;

  assign cur_phase   = line_start ? xalt_pkg::PH_LEAD : phase;
  assign cur_outcome = line_start ? xalt_pkg::ST_PARSING : outcome;
  assign is_lower    = (char_code >= 8'h61) && (char_code <= 8'h7A);
  assign is_digit    = (char_code >= 8'h30) && (char_code <= 8'h39);
  assign is_key      = is_lower || is_digit;

  always_comb begin
    step.phase_next   = cur_phase;
    step.outcome_next = cur_outcome;
    step.token_class  = xalt_pkg::CL_MARK;
    step.pair_end     = 1'b0;
    reject            = 1'b0;
    unique case (cur_phase)
      xalt_pkg::PH_LEAD: begin
        priority if (char_code == xalt_pkg::CH_SPACE || char_code == xalt_pkg::CH_TAB)
          step.token_class = xalt_pkg::CL_BLANK;
        else if (char_code == xalt_pkg::CH_LT) step.phase_next = xalt_pkg::PH_TAG;
        else reject = 1'b1;
      end
      xalt_pkg::PH_TAG: begin
        priority if (is_lower || char_code == xalt_pkg::CH_COLON)
          step.token_class = xalt_pkg::CL_TAG;
        else if (char_code == xalt_pkg::CH_SPACE) step.phase_next = xalt_pkg::PH_GAP;
        else reject = 1'b1;
      end
      xalt_pkg::PH_GAP: begin
        priority if (char_code == xalt_pkg::CH_SPACE) step.token_class = xalt_pkg::CL_BLANK;
        else if (char_code == xalt_pkg::CH_SLASH) step.phase_next = xalt_pkg::PH_SLASH;
        else if (is_key) begin
          step.token_class = xalt_pkg::CL_KEY;
          step.phase_next  = xalt_pkg::PH_KEY;
        end else reject = 1'b1;
      end
      xalt_pkg::PH_KEY: begin
        priority if (is_key) step.token_class = xalt_pkg::CL_KEY;
        else if (char_code == xalt_pkg::CH_EQ) step.phase_next = xalt_pkg::PH_EQ;
        else reject = 1'b1;
      end
      xalt_pkg::PH_EQ: begin
        if (char_code == xalt_pkg::CH_QUOTE) step.phase_next = xalt_pkg::PH_VALUE;
        else reject = 1'b1;
      end
      xalt_pkg::PH_VALUE: begin
        priority if (char_code == xalt_pkg::CH_QUOTE) begin
          step.pair_end   = 1'b1;
          step.phase_next = xalt_pkg::PH_GAP;
        end else if (char_code == xalt_pkg::CH_NUL) reject = 1'b1;
        else step.token_class = xalt_pkg::CL_VALUE;
      end
      xalt_pkg::PH_SLASH: begin
        if (char_code == xalt_pkg::CH_GT) begin
          step.outcome_next = xalt_pkg::ST_ACCEPTED;
          step.phase_next   = xalt_pkg::PH_DONE;
        end else reject = 1'b1;
      end
      xalt_pkg::PH_DONE: begin
        step.token_class = xalt_pkg::CL_AFTER;
      end
    endcase
    if (reject) begin
      step.outcome_next = xalt_pkg::ST_REJECTED;
      step.phase_next   = xalt_pkg::PH_DONE;
      step.token_class  = xalt_pkg::CL_MARK;
      step.pair_end     = 1'b0;
    end
  end

endmodule

// File: src/xml_attribute_line_tokenizer_top.sv
// Top level of the XML attribute line tokenizer: parser state and result register.

// This block checks one-line self-closing XML elements of the form <tag key="value" ... />,
// one byte per transfer, and returns exactly one result per byte: the byte itself, its
// token class, a pair_end flag on the closing quote of each key-value pair, and the line
// status (parsing, accepted at "/>", or rejected at the first byte that breaks the pattern
// or at NUL). Bytes after the decision are classed "after decision" and repeat the stored
// status. Raise line_start with the first byte of each new line; it restarts the parser
// before that byte is looked at. The classification is a shallow decision on the stored
// phase and the new byte, written straight into the result register, so the block takes
// one byte per cycle for as long as results are drained, and the result is valid in the
// cycle after the input transfer. A new byte is taken in the same cycle that a waiting
// result is taken on the output side.
module xml_attribute_line_tokenizer_top (
  input  logic       clk,
  input  logic       rst,
  input  logic [7:0] char_code,
  input  logic       line_start,
  input  logic       in_valid,
  output logic       in_ready,
  output logic [7:0] char_echo,
  output logic [2:0] token_class,
  output logic       pair_end,
  output logic [1:0] status,
  output logic       out_valid,
  input  logic       out_ready
);

  // Parser state carried from byte to byte.
  logic [2:0] phase;
  logic [1:0] outcome;

  logic                 in_fire;
  xalt_pkg::xalt_step_t step;

  // The result register may be refilled when it is empty or drained in this cycle.
  assign in_ready = !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;

  xalt_classify u_classify (
    .phase      (phase),
    .outcome    (outcome),
    .char_code  (char_code),
    .line_start (line_start),
    .step       (step)
  );

  // Phase and outcome advance only on an input transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= xalt_pkg::PH_LEAD;
      outcome <= xalt_pkg::ST_PARSING;
    end else if (in_fire) begin
      phase   <= step.phase_next;
      outcome <= step.outcome_next;
    end
  end

  // Result register: valid flag is control, the payload loads on every transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      char_echo   <= char_code;
      token_class <= step.token_class;
      pair_end    <= step.pair_end;
      status      <= step.outcome_next;
    end
  end

  // A pair only ends on a closing quote, which is a syntax mark.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && pair_end |-> token_class == xalt_pkg::CL_MARK && char_echo == xalt_pkg::CH_QUOTE)
    else $error("pair_end on a byte that is not a closing quote");

  // Bytes after the decision always report a decided line.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && token_class == xalt_pkg::CL_AFTER |-> status != xalt_pkg::ST_PARSING)
    else $error("after-decision byte reports a line still parsing");

  // Once decided, a byte without line_start is classed after decision.
  assert property (@(posedge clk) disable iff (rst)
    in_fire && !line_start && phase == xalt_pkg::PH_DONE |=> token_class == xalt_pkg::CL_AFTER)
    else $error("byte after decision not classed as such");

  // The done phase and a decided outcome go together.
  assert property (@(posedge clk) disable iff (rst)
    (phase == xalt_pkg::PH_DONE) == (outcome != xalt_pkg::ST_PARSING))
    else $error("parser phase and outcome disagree");

endmodule
